// ===== rtl/homography_reprojection_error_macros.svh =====
// Assertion macros shared by the homography reprojection error checks.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef HOMOGRAPHY_REPROJECTION_ERROR_MACROS_SVH
`define HOMOGRAPHY_REPROJECTION_ERROR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hre check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hre check failed");

// Next-cycle implication that also holds during reset, so registers have taken
// their reset values before the consequent is checked.
`define HRE_ASSERT_ALL(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hre check failed");

`endif

// ===== rtl/hre_pkg.sv =====
// Shared types and constants of the homography reprojection error block.
// Used by the top level, the divider pipeline and the port checker.
package hre_pkg;

  localparam int COEF_W     = 21;   // signed Q2.19 coefficient
  localparam int COORD_W    = 24;   // signed Q16.8 coordinate
  localparam int REG_W      = 63;   // three packed coefficients
  localparam int ADDR_W     = 5;    // registers at byte offsets 0, 8, 16
  localparam int DATA_W     = 64;
  localparam int FRAC_SHIFT = 8;    // numerator scale for a Q.8 quotient
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W - 1;
  localparam int QUO_W      = 28;   // floor quotient bits kept before overflow
  localparam int RQ_W       = QUO_W + 1;
  localparam int DIV_LAT    = QUO_W + 2;
  localparam int DIFF_W     = RQ_W + 2;
  localparam int ESUM_W     = DIFF_W + 1;
  localparam int ERR_W      = 26;
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  localparam logic [REG_W-1:0] ROW_ZERO_RST = 63'd524288;
  localparam logic [REG_W-1:0] ROW_ONE_RST  = 63'd1099511627776;
  localparam logic [REG_W-1:0] ROW_TWO_RST  = 63'd2305843009213693952;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ROW_ZERO = 2'd0,
    REG_ROW_ONE  = 2'd1,
    REG_ROW_TWO  = 2'd2
  } reg_idx_e;

endpackage

// ===== rtl/hre_div.sv =====
// Pipelined restoring divider: rounds (num * 256) / den to nearest, ties up.
// One quotient bit per stage plus entry and rounding stages; uses hre_pkg.
module hre_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hre_pkg::MAG_W-1:0] num_i,
  input  logic [hre_pkg::MAG_W-1:0] den_i,
  output logic [hre_pkg::RQ_W-1:0]  quo_o,
  output logic                      ovf_o
);
  import hre_pkg::*;

  localparam int LowNumW = QUO_W - FRAC_SHIFT;
  localparam int HiW     = MAG_W - LowNumW;

  logic [MAG_W-1:0] rem_q [QUO_W+1];
  logic [MAG_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [MAG_W-1:0] hi_w;
  logic             up_w;
  logic [RQ_W-1:0]  round_q;
  logic             ovf_out_q;

  // The scaled numerator above the kept quotient bits must lie below the
  // divisor, else the quotient needs more than QUO_W bits.
  assign hi_w = {{(MAG_W-HiW){1'b0}}, num_i[MAG_W-1:LowNumW]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_w;
      low_q[0] <= {num_i[LowNumW-1:0], {FRAC_SHIFT{1'b0}}};
      den_q[0] <= den_i;
      ovf_q[0] <= (hi_w >= den_i);
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_step
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;

    assign trial = {rem_q[i-1], low_q[i-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[i-1]};
    assign ge    = (trial >= {1'b0, den_q[i-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        quo_q[i] <= {quo_q[i-1][QUO_W-2:0], ge};
        den_q[i] <= den_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end

    if (i < QUO_W) begin : g_low
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q[i] <= {low_q[i-1][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // Round up when twice the remainder reaches the divisor.
  assign up_w = ({rem_q[QUO_W], 1'b0} >= {1'b0, den_q[QUO_W]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      round_q   <= {1'b0, quo_q[QUO_W]} + RQ_W'(up_w);
      ovf_out_q <= ovf_q[QUO_W];
    end
  end

  assign quo_o = round_q;
  assign ovf_o = ovf_out_q;

endmodule

// ===== rtl/homography_reprojection_error.sv =====
// Homography reprojection error, L1, one correspondence per request.
// Throughput: one request per cycle unless stalled; the two 30-stage divider pipelines
// set the depth. A held result stalls the pipeline only when the last stage also holds
// an item. Reset clears all valid bits and loads the identity into the three row
// registers.
module homography_reprojection_error (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hre_pkg::ADDR_W-1:0]         paddr,
  input  logic [hre_pkg::DATA_W-1:0]         pwdata,
  output logic [hre_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [hre_pkg::COORD_W-1:0] src_x_i,
  input  logic signed [hre_pkg::COORD_W-1:0] src_y_i,
  input  logic signed [hre_pkg::COORD_W-1:0] dst_x_i,
  input  logic signed [hre_pkg::COORD_W-1:0] dst_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [hre_pkg::ERR_W-1:0]          reproj_error_o,
  output logic [1:0]                         status_o
);
  import hre_pkg::*;

  logic [REG_W-1:0]         row_q [3];
  logic signed [COEF_W-1:0] coef_w [3][3];
  logic signed [SUM_W-1:0]  bias_w [3];
  logic                     wr_w;
  logic                     en_w;

  // Stage 1: products
  logic signed [PROD_W-1:0]  prod_q [3][2];
  logic signed [COORD_W-1:0] dx1_q, dy1_q;
  logic                      v1_q;
  // Stage 2: row sums
  logic signed [SUM_W-1:0]   sum_q [3];
  logic signed [COORD_W-1:0] dx2_q, dy2_q;
  logic                      v2_q;
  // Stage 3: magnitudes and signs
  logic [MAG_W-1:0]          mag_q [3];
  logic signed [COORD_W-1:0] dx3_q, dy3_q;
  logic                      negx3_q, negy3_q, zero3_q, v3_q;
  // Side data that travels with the dividers
  logic signed [COORD_W-1:0] dxd_q [DIV_LAT];
  logic signed [COORD_W-1:0] dyd_q [DIV_LAT];
  logic                      negxd_q [DIV_LAT];
  logic                      negyd_q [DIV_LAT];
  logic                      zerod_q [DIV_LAT];
  logic                      vd_q [DIV_LAT];
  logic [RQ_W-1:0]           qx_w, qy_w;
  logic                      ovfx_w, ovfy_w;
  // Stage 4: signed differences
  logic signed [RQ_W:0]      px_w, py_w;
  logic signed [DIFF_W-1:0]  diffx_q, diffy_q;
  logic                      ovf4_q, zero4_q, v4_q;
  // Output register
  logic [DIFF_W-1:0]         absx_w, absy_w;
  logic [ESUM_W-1:0]         esum_w;
  logic [ERR_W-1:0]          err_d, err_q;
  status_e                   status_d, status_q;
  logic                      out_valid_q;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign wr_w   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_ZERO_RST;
      row_q[1] <= ROW_ONE_RST;
      row_q[2] <= ROW_TWO_RST;
    end else if (wr_w) begin
      case (reg_idx_e'(paddr[ADDR_W-1:3]))
        REG_ROW_ZERO: row_q[0] <= pwdata[REG_W-1:0];
        REG_ROW_ONE:  row_q[1] <= pwdata[REG_W-1:0];
        REG_ROW_TWO:  row_q[2] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[ADDR_W-1:3]))
      REG_ROW_ZERO: prdata = {1'b0, row_q[0]};
      REG_ROW_ONE:  prdata = {1'b0, row_q[1]};
      REG_ROW_TWO:  prdata = {1'b0, row_q[2]};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef_w[r][c] = row_q[r][c*COEF_W +: COEF_W];
      end
      bias_w[r] = {{(SUM_W-COEF_W-FRAC_SHIFT){coef_w[r][2][COEF_W-1]}}, coef_w[r][2],
                   {FRAC_SHIFT{1'b0}}};
    end
  end

  // -------------------------------------------------------------- pipeline
  // The pipeline moves unless the last stage and the output register both
  // hold a result that has not been taken.
  assign en_w       = ~out_valid_q | out_ready_i | ~v4_q;
  assign in_ready_o = en_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en_w) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vd_q[0] <= v3_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      v4_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= coef_w[r][0] * src_x_i;
        prod_q[r][1] <= coef_w[r][1] * src_y_i;
      end
      dx1_q <= dst_x_i;
      dy1_q <= dst_y_i;

      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= {{(SUM_W-PROD_W){prod_q[r][0][PROD_W-1]}}, prod_q[r][0]}
                  + {{(SUM_W-PROD_W){prod_q[r][1][PROD_W-1]}}, prod_q[r][1]}
                  + bias_w[r];
      end
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;

      for (int r = 0; r < 3; r++) begin
        mag_q[r] <= sum_q[r][SUM_W-1] ? MAG_W'(-sum_q[r]) : sum_q[r][MAG_W-1:0];
      end
      negx3_q <= sum_q[0][SUM_W-1] ^ sum_q[2][SUM_W-1];
      negy3_q <= sum_q[1][SUM_W-1] ^ sum_q[2][SUM_W-1];
      zero3_q <= (sum_q[2] == '0);
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;

      dxd_q[0]   <= dx3_q;
      dyd_q[0]   <= dy3_q;
      negxd_q[0] <= negx3_q;
      negyd_q[0] <= negy3_q;
      zerod_q[0] <= zero3_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dxd_q[i]   <= dxd_q[i-1];
        dyd_q[i]   <= dyd_q[i-1];
        negxd_q[i] <= negxd_q[i-1];
        negyd_q[i] <= negyd_q[i-1];
        zerod_q[i] <= zerod_q[i-1];
      end

      diffx_q <= {px_w[RQ_W], px_w}
               - {{(DIFF_W-COORD_W){dxd_q[DIV_LAT-1][COORD_W-1]}}, dxd_q[DIV_LAT-1]};
      diffy_q <= {py_w[RQ_W], py_w}
               - {{(DIFF_W-COORD_W){dyd_q[DIV_LAT-1][COORD_W-1]}}, dyd_q[DIV_LAT-1]};
      ovf4_q  <= ovfx_w | ovfy_w;
      zero4_q <= zerod_q[DIV_LAT-1];
    end
  end

  hre_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en_w),
    .num_i (mag_q[0]),
    .den_i (mag_q[2]),
    .quo_o (qx_w),
    .ovf_o (ovfx_w)
  );

  hre_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en_w),
    .num_i (mag_q[1]),
    .den_i (mag_q[2]),
    .quo_o (qy_w),
    .ovf_o (ovfy_w)
  );

  assign px_w = negxd_q[DIV_LAT-1] ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
  assign py_w = negyd_q[DIV_LAT-1] ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});

  // ---------------------------------------------------------------- output
  assign absx_w = diffx_q[DIFF_W-1] ? DIFF_W'(-diffx_q) : diffx_q;
  assign absy_w = diffy_q[DIFF_W-1] ? DIFF_W'(-diffy_q) : diffy_q;
  assign esum_w = {1'b0, absx_w} + {1'b0, absy_w};

  // A quotient overflow already puts the error far above the maximum.
  always_comb begin
    if (zero4_q) begin
      err_d    = ERR_MAX;
      status_d = ST_ZERO_DEN;
    end else if (ovf4_q || (esum_w > ESUM_W'(ERR_MAX))) begin
      err_d    = ERR_MAX;
      status_d = ST_SAT;
    end else begin
      err_d    = esum_w[ERR_W-1:0];
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_w && v4_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w && v4_q) begin
      err_q    <= err_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reproj_error_o = err_q;
  assign status_o       = status_q;

endmodule

// ===== rtl/hre_checker.sv =====
// Port-level checks of the homography reprojection error block, bound to its top.
// Uses hre_pkg and the assertion macros header.
`include "homography_reprojection_error_macros.svh"

module hre_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [hre_pkg::ERR_W-1:0] reproj_error_o,
  input logic [1:0]                status_o
);
  import hre_pkg::*;

  // A zero denominator reports the largest error.
  `HRE_ASSERT_IMP(a_zero_den_max, clk_i, rst_ni, out_valid_o && (status_o == ST_ZERO_DEN), reproj_error_o == ERR_MAX)

  // A saturated error is clamped to the largest code.
  `HRE_ASSERT_IMP(a_sat_max, clk_i, rst_ni, out_valid_o && (status_o == ST_SAT), reproj_error_o == ERR_MAX)

  // A result that is not taken stays put.
  `HRE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(reproj_error_o) && $stable(status_o))

  // No result is offered while reset is asserted.
  `HRE_ASSERT_ALL(a_reset_idle, clk_i, !rst_ni, !out_valid_o)

endmodule

bind homography_reprojection_error hre_checker u_hre_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for homography_reprojection_error: point pairs in, L1 errors out.
// Rows are loaded over APB between phases and each result is predicted here bit for bit.
// Depends on hre_pkg and the top level of the block.
module tb_top;
  import hre_pkg::*;

  localparam int HOLD_MAX        = 15;
  localparam int DRAIN_CYCLES    = 40;     // extra wait after the queues have emptied
  localparam int DRAIN_LIMIT     = 20000;
  localparam int RAND_PHASES     = 13;
  localparam int PAIRS_PER_PHASE = 127;
  localparam int PRINT_LIMIT     = 100;

  localparam logic [ADDR_W-1:0] UNUSED_ADDR = 5'd24;   // decodes to no register

  localparam longint COEF_MAX = 1048575;
  localparam longint COEF_MIN = -1048576;
  localparam longint COEF_ONE = 524288;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum int {
    WARP_NEAR,
    WARP_PERSP,
    WARP_WILD,
    WARP_EXTREME,
    WARP_DEGEN
  } warp_kind_e;

  typedef struct {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } corr_t;

  typedef struct {
    logic [ERR_W-1:0] err;
    status_e          st;
  } reproj_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      psel           = 1'b0;
  logic                      penable        = 1'b0;
  logic                      pwrite         = 1'b0;
  logic [ADDR_W-1:0]         paddr          = '0;
  logic [DATA_W-1:0]         pwdata         = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] src_x_i        = '0;
  logic signed [COORD_W-1:0] src_y_i        = '0;
  logic signed [COORD_W-1:0] dst_x_i        = '0;
  logic signed [COORD_W-1:0] dst_y_i        = '0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic [ERR_W-1:0]          reproj_error_o;
  logic [1:0]                status_o;

  // Local copy of the three row registers, updated as each write lands.
  logic [REG_W-1:0] h_row [3];

  corr_t   pair_q[$];
  reproj_t err_due_q[$];
  corr_t   next_pair;
  reproj_t want;

  int idle_pct  = 0;
  int send_gap  = 0;
  int rcv_gap   = 0;
  int fail_cnt  = 0;
  int sent_cnt  = 0;
  int got_cnt   = 0;
  int zero_cnt  = 0;
  int sat_cnt   = 0;

  homography_reprojection_error u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic note_mismatch(string msg);
    fail_cnt++;
    if (fail_cnt <= PRINT_LIMIT) begin
      $display("tb_top: mismatch: %s", msg);
    end
  endtask

  function automatic longint coef_at(logic [REG_W-1:0] row, int col);
    logic signed [COEF_W-1:0] c;
    c = row[col*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  function automatic longint row_sum(logic [REG_W-1:0] row, longint x, longint y);
    return coef_at(row, 0) * x + coef_at(row, 1) * y + coef_at(row, 2) * 256;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  // Q.8 quotient of n / d, rounded to nearest with ties away from zero.
  function automatic longint q8_round(longint n, longint d);
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    an = abs64(n) << FRAC_SHIFT;
    ad = abs64(d);
    q  = ((an << 1) + ad) / (ad << 1);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Returns 0 when the projective denominator is zero.
  function automatic bit project_pt(logic signed [COORD_W-1:0] sx,
                                    logic signed [COORD_W-1:0] sy,
                                    output longint px, output longint py);
    longint x;
    longint y;
    longint w;
    x  = sx;
    y  = sy;
    px = 0;
    py = 0;
    w  = row_sum(h_row[REG_ROW_TWO], x, y);
    if (w == 0) begin
      return 1'b0;
    end
    px = q8_round(row_sum(h_row[REG_ROW_ZERO], x, y), w);
    py = q8_round(row_sum(h_row[REG_ROW_ONE], x, y), w);
    return 1'b1;
  endfunction

  function automatic reproj_t calc_reproj(corr_t c);
    reproj_t     r;
    longint      px;
    longint      py;
    logic [63:0] e;
    if (!project_pt(c.sx, c.sy, px, py)) begin
      r.err = ERR_MAX;
      r.st  = ST_ZERO_DEN;
      return r;
    end
    e = abs64(px - c.dx) + abs64(py - c.dy);
    if (e > ERR_MAX) begin
      r.err = ERR_MAX;
      r.st  = ST_SAT;
    end else begin
      r.err = e[ERR_W-1:0];
      r.st  = ST_OK;
    end
    return r;
  endfunction

  // Signed random value in [-2^bits, 2^bits - 1].
  function automatic longint rand_span(int bits);
    longint v;
    v = {$urandom(), $urandom()};
    return v >>> (63 - bits);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int     pick;
    longint v;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      v = 0;
    end else if (pick < 60) begin
      v = rand_span(15);
    end else if (pick < 85) begin
      v = rand_span(19);
    end else begin
      v = rand_span(23);
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > longint'(C_MAX)) begin
      return C_MAX;
    end
    if (v < longint'(C_MIN)) begin
      return C_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 5))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return COEF_ONE;
    endcase
  endfunction

  // Bit 63 stays random: the block has to ignore it.
  function automatic logic [DATA_W-1:0] pack_row(longint c0, longint c1, longint c2);
    logic [DATA_W-1:0] d;
    d = {$urandom(), $urandom()};
    d[COEF_W-1:0]            = c0[COEF_W-1:0];
    d[2*COEF_W-1:COEF_W]     = c1[COEF_W-1:0];
    d[3*COEF_W-1:2*COEF_W]   = c2[COEF_W-1:0];
    return d;
  endfunction

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    logic [1:0] idx;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    idx = addr[ADDR_W-1:3];
    if (addr[2:0] == 3'b000 &&
        (idx == REG_ROW_ZERO || idx == REG_ROW_ONE || idx == REG_ROW_TWO)) begin
      h_row[idx] = data[REG_W-1:0];
    end
    @(negedge clk_i);
  endtask

  task automatic load_rows(logic [DATA_W-1:0] r0, logic [DATA_W-1:0] r1,
                           logic [DATA_W-1:0] r2);
    apb_write({REG_ROW_ZERO, 3'b000}, r0);
    apb_write({REG_ROW_ONE, 3'b000}, r1);
    apb_write({REG_ROW_TWO, 3'b000}, r2);
  endtask

  task automatic load_homography(warp_kind_e kind);
    int sp;
    sp = (kind == WARP_PERSP) ? 10 : 5;
    case (kind)
      WARP_NEAR, WARP_PERSP: begin
        load_rows(pack_row(COEF_ONE + rand_span(14), rand_span(14), rand_span(20)),
                  pack_row(rand_span(14), COEF_ONE + rand_span(14), rand_span(20)),
                  pack_row(rand_span(sp), rand_span(sp), COEF_ONE + rand_span(14)));
      end
      WARP_WILD: begin
        load_rows({$urandom(), $urandom()}, {$urandom(), $urandom()},
                  {$urandom(), $urandom()});
      end
      WARP_EXTREME: begin
        load_rows(pack_row(pick_extreme(), pick_extreme(), pick_extreme()),
                  pack_row(pick_extreme(), pick_extreme(), pick_extreme()),
                  pack_row(pick_extreme(), pick_extreme(), pick_extreme()));
      end
      default: begin
        // No constant term: the denominator vanishes along a line through the origin.
        load_rows({$urandom(), $urandom()}, {$urandom(), $urandom()},
                  pack_row(rand_span(2), rand_span(2), 0));
      end
    endcase
  endtask

  task automatic queue_pair(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                            logic signed [COORD_W-1:0] dx, logic signed [COORD_W-1:0] dy);
    corr_t c;
    c.sx = sx;
    c.sy = sy;
    c.dx = dx;
    c.dy = dy;
    pair_q = {pair_q, c};
  endtask

  // Most pairs are true matches: the second point sits near the projected first one.
  task automatic queue_random_pair();
    corr_t  c;
    longint px;
    longint py;
    int     noise;
    c.sx  = rand_coord();
    c.sy  = rand_coord();
    noise = $urandom_range(1, 14);
    if ($urandom_range(0, 9) < 7 && project_pt(c.sx, c.sy, px, py)) begin
      c.dx = clamp_coord(px + rand_span(noise));
      c.dy = clamp_coord(py + rand_span(noise));
    end else begin
      c.dx = rand_coord();
      c.dy = rand_coord();
    end
    pair_q = {pair_q, c};
  endtask

  task automatic wait_drained();
    int spins;
    spins = 0;
    do begin
      @(negedge clk_i);
      spins++;
    end while ((pair_q.size() != 0 || in_valid_i || err_due_q.size() != 0) &&
               spins < DRAIN_LIMIT);
  endtask

  // Request side: present queued pairs, with random gaps between them.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        err_due_q = {err_due_q,
                     calc_reproj(corr_t'{src_x_i, src_y_i, dst_x_i, dst_y_i})};
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pair_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, HOLD_MAX) - 1;
          in_valid_i <= 1'b0;
        end else if (pair_q.size() != 0) begin
          next_pair = pair_q.pop_front();
          src_x_i    <= next_pair.sx;
          src_y_i    <= next_pair.sy;
          dst_x_i    <= next_pair.dx;
          dst_y_i    <= next_pair.dy;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_cnt++;
        if (err_due_q.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = err_due_q.pop_front();
          if (reproj_error_o !== want.err) begin
            note_mismatch($sformatf("result %0d: reproj_error %0d, expected %0d",
                                    got_cnt, reproj_error_o, want.err));
          end
          if (status_o !== want.st) begin
            note_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    got_cnt, status_o, want.st));
          end
          if (want.st == ST_ZERO_DEN) begin
            zero_cnt++;
          end
          if (want.st == ST_SAT) begin
            sat_cnt++;
          end
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        rcv_gap = $urandom_range(1, HOLD_MAX) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    h_row[REG_ROW_ZERO] = ROW_ZERO_RST;
    h_row[REG_ROW_ONE]  = ROW_ONE_RST;
    h_row[REG_ROW_TWO]  = ROW_TWO_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The reset rows form the identity, so the error is the plain coordinate distance.
    idle_pct = 10;
    queue_pair('0, '0, '0, '0);
    queue_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    queue_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    queue_pair(C_MAX, C_MIN, C_MIN, C_MAX);
    queue_pair(C_MIN, C_MAX, C_MAX, C_MIN);

    // An all-zero third row gives a zero denominator for every point; the write to
    // the unused address must change nothing.
    wait_drained();
    apb_write(UNUSED_ADDR, {$urandom(), $urandom()});
    apb_write({REG_ROW_TWO, 3'b000}, {1'b1, {REG_W{1'b0}}});
    queue_pair('0, '0, C_MAX, C_MIN);
    queue_pair(C_MAX, C_MIN, '0, '0);
    queue_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord());

    // Extreme coefficients over a tiny denominator push the error into saturation.
    wait_drained();
    load_rows(pack_row(COEF_MAX, COEF_MAX, COEF_MAX), pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
              pack_row(0, 0, 1));
    queue_pair('0, '0, '0, '0);
    queue_pair(C_MAX, C_MAX, C_MIN, C_MIN);
    queue_pair(C_MIN, C_MIN, C_MAX, C_MAX);

    // Denominator equals src_x: exact half quotients, signs of both kinds, and zero.
    wait_drained();
    load_rows(pack_row(0, 0, 1), pack_row(0, 0, -1), pack_row(1, 0, 0));
    queue_pair(24'sd131072, rand_coord(), '0, '0);
    queue_pair(-24'sd131072, rand_coord(), '0, '0);
    queue_pair('0, rand_coord(), C_MAX, C_MAX);
    queue_pair(24'sd1, rand_coord(), C_MIN, C_MAX);
    queue_pair(-24'sd1, rand_coord(), C_MAX, C_MIN);

    // Each random phase waits for the pipeline to empty before reloading the rows.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      idle_pct = (p == RAND_PHASES - 1) ? 0 : (p % 4) * 10;
      load_homography(warp_kind_e'(p % 5));
      repeat (PAIRS_PER_PHASE) queue_random_pair();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_due_q.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", err_due_q.size()));
    end

    $display("tb_top: %0d point pairs scored under %0d homography settings",
             sent_cnt, 4 + RAND_PHASES);
    $display("tb_top: %0d results checked, %0d zero denominator, %0d saturated",
             got_cnt, zero_cnt, sat_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hre_pkg.sv
rtl/hre_div.sv
rtl/homography_reprojection_error.sv
rtl/hre_checker.sv
sim/tb_top.sv
